// ----- sv/chained_hash_table_assert.svh -----
`ifndef CHAINED_HASH_TABLE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ASSERT_SVH

// Checks that a condition implies another in the same cycle.
`define CHT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies another in the following cycle.
`define CHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/cht_pkg.sv -----
package cht_pkg;

  localparam int BUCKETS    = 64;
  localparam int NODES      = 64;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  // Port widths are fixed by the interface.
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int KEY_PORT_W = 32;
  localparam int VAL_PORT_W = 32;

  localparam int KEY_W = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
  localparam int VAL_W = (VALUE_BITS < VAL_PORT_W) ? VALUE_BITS : VAL_PORT_W;
  localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int CNT_W = (KEY_W > 1) ? $clog2(KEY_W) : 1;

  // A power-of-two bucket count takes the bucket straight from the low key bits.
  localparam bit BKT_FAST = (BUCKETS > 1) && ((BUCKETS & (BUCKETS - 1)) == 0);

  localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } ptr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_PUT,
    S_FIRST,
    S_WALK,
    S_FREE,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [BKT_W-1:0] bkt_rd_addr;
    logic             bkt_we;
    logic [BKT_W-1:0] bkt_wr_addr;
    ptr_t             bkt_wr_data;
    logic [IDX_W-1:0] node_rd_addr;
    logic             node_we;
    logic [IDX_W-1:0] node_wr_addr;
    logic [KEY_W-1:0] node_key;
    logic [VAL_W-1:0] node_val;
    logic             link_we;
    logic [IDX_W-1:0] link_wr_addr;
    ptr_t             link_wr_data;
  } mem_req_t;

endpackage

// ----- sv/cht_store.sv -----
module cht_store (
  input  logic                    clk,
  input  logic                    rst,
  input  cht_pkg::mem_req_t       req,
  output cht_pkg::ptr_t           bkt_rd,
  output logic [cht_pkg::KEY_W-1:0] key_rd,
  output logic [cht_pkg::VAL_W-1:0] val_rd,
  output cht_pkg::ptr_t           link_rd
);
  import cht_pkg::*;

  logic [IDX_W-1:0] bkt_mem [BUCKETS];
  logic [BUCKETS-1:0] bkt_vld;
  logic [IDX_W-1:0] bkt_q_idx;
  logic             bkt_q_vld;

  logic [KEY_W-1:0] key_mem [NODES];
  logic [VAL_W-1:0] val_mem [NODES];
  logic [IDX_W-1:0] link_mem [NODES];
  logic [NODES-1:0] link_vld;
  logic [NODES-1:0] link_set;
  logic [IDX_W-1:0] link_q_idx;
  logic             link_q_vld;
  logic             link_q_set;
  logic [IDX_W-1:0] link_q_addr;

  always_ff @(posedge clk) begin
    if (req.bkt_we) begin
      bkt_mem[req.bkt_wr_addr] <= req.bkt_wr_data.idx;
    end
    bkt_q_idx <= bkt_mem[req.bkt_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bkt_vld   <= '0;
      bkt_q_vld <= 1'b0;
    end else begin
      if (req.bkt_we) begin
        bkt_vld[req.bkt_wr_addr] <= req.bkt_wr_data.valid;
      end
      bkt_q_vld <= bkt_vld[req.bkt_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.node_we) begin
      key_mem[req.node_wr_addr] <= req.node_key;
      val_mem[req.node_wr_addr] <= req.node_val;
    end
    key_rd <= key_mem[req.node_rd_addr];
    val_rd <= val_mem[req.node_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_wr_addr] <= req.link_wr_data.idx;
    end
    link_q_idx  <= link_mem[req.node_rd_addr];
    link_q_addr <= req.node_rd_addr;
  end

  // After reset every node links to the next one; the last node has no link.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NODES; i++) begin
        link_vld[i] <= (i + 1 < NODES);
      end
      link_set   <= '0;
      link_q_vld <= 1'b0;
      link_q_set <= 1'b0;
    end else begin
      if (req.link_we) begin
        link_vld[req.link_wr_addr] <= req.link_wr_data.valid;
        link_set[req.link_wr_addr] <= 1'b1;
      end
      link_q_vld <= link_vld[req.node_rd_addr];
      link_q_set <= link_set[req.node_rd_addr];
    end
  end

  assign bkt_rd.idx    = bkt_q_idx;
  assign bkt_rd.valid  = bkt_q_vld;
  assign link_rd.idx   = link_q_set ? link_q_idx : link_q_addr + IDX_W'(1);
  assign link_rd.valid = link_q_vld;

endmodule

// ----- sv/cht_seq.sv -----
module cht_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [cht_pkg::CMD_W-1:0]      cmd,
  input  logic [cht_pkg::KEY_PORT_W-1:0] key,
  input  logic [cht_pkg::VAL_PORT_W-1:0] value,
  input  logic                         in_valid,
  output logic                         in_ready,
  output logic [cht_pkg::STATUS_W-1:0]   status,
  output logic                         found,
  output logic [cht_pkg::VAL_PORT_W-1:0] value_out,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cht_pkg::mem_req_t            req,
  input  cht_pkg::ptr_t                bkt_rd,
  input  logic [cht_pkg::KEY_W-1:0]      key_rd,
  input  logic [cht_pkg::VAL_W-1:0]      val_rd,
  input  cht_pkg::ptr_t                link_rd
);
  import cht_pkg::*;

  state_t state, state_next;

  logic [CMD_W-1:0]    cmd_q;
  logic [KEY_W-1:0]    key_q;
  logic [VAL_W-1:0]    val_q;
  logic [BKT_W-1:0]    bkt;
  logic [CNT_W-1:0]    cnt;
  ptr_t                cur;
  ptr_t                prev;
  ptr_t                free_head;
  logic [STATUS_W-1:0] res_status;
  logic                res_found;
  logic [VAL_W-1:0]    res_value;
  logic [VAL_W-1:0]    out_value;

  logic [KEY_W+BKT_W-1:0] key_ext;
  logic [BKT_W:0]         rem_shift;
  logic [BKT_W-1:0]       rem_next;
  logic                   hit;
  logic                   out_load;

  assign key_ext   = (KEY_W + BKT_W)'(key[KEY_W-1:0]);
  assign hit       = (key_rd == key_q);
  assign out_load  = (state == S_RESULT) && (!out_valid || out_ready);

  // One key bit per cycle, most significant first, through a restoring reduction.
  assign rem_shift = {bkt, key_q[cnt]};
  assign rem_next  = (rem_shift >= (BKT_W + 1)'(BUCKETS)) ?
                     BKT_W'(rem_shift - (BKT_W + 1)'(BUCKETS)) : BKT_W'(rem_shift);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = BKT_FAST ? S_HEAD : S_HASH;
        end
      end
      S_HASH: begin
        if (cnt == '0) begin
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        case (cmd_q)
          CMD_PUT:    state_next = free_head.valid ? S_PUT : S_RESULT;
          CMD_GET:    state_next = S_FIRST;
          CMD_REMOVE: state_next = S_FIRST;
          default:    state_next = S_RESULT;
        endcase
      end
      S_PUT:   state_next = S_RESULT;
      S_FIRST: state_next = bkt_rd.valid ? S_WALK : S_RESULT;
      S_WALK: begin
        if (hit) begin
          state_next = (cmd_q == CMD_REMOVE) ? S_FREE : S_RESULT;
        end else if (!link_rd.valid) begin
          state_next = S_RESULT;
        end
      end
      S_FREE: state_next = S_RESULT;
      S_RESULT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = (state == S_IDLE);
    req              = '0;
    req.bkt_rd_addr  = bkt;
    req.node_rd_addr = link_rd.idx;
    req.node_wr_addr = free_head.idx;
    req.node_key     = key_q;
    req.node_val     = val_q;
    req.bkt_wr_addr  = bkt;
    case (state)
      S_HEAD:  req.node_rd_addr = free_head.idx;
      S_FIRST: req.node_rd_addr = bkt_rd.idx;
      S_PUT: begin
        req.node_we           = 1'b1;
        req.link_we           = 1'b1;
        req.link_wr_addr      = free_head.idx;
        req.link_wr_data      = bkt_rd;
        req.bkt_we            = 1'b1;
        req.bkt_wr_data.idx   = free_head.idx;
        req.bkt_wr_data.valid = 1'b1;
      end
      S_WALK: begin
        // Unlink the matched node from its predecessor or from the bucket head.
        if (hit && cmd_q == CMD_REMOVE) begin
          if (prev.valid) begin
            req.link_we      = 1'b1;
            req.link_wr_addr = prev.idx;
            req.link_wr_data = link_rd;
          end else begin
            req.bkt_we      = 1'b1;
            req.bkt_wr_data = link_rd;
          end
        end
      end
      S_FREE: begin
        req.link_we      = 1'b1;
        req.link_wr_addr = cur.idx;
        req.link_wr_data = free_head;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      free_head.idx   <= '0;
      free_head.valid <= 1'b1;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_PUT) begin
        free_head <= link_rd;
      end else if (state == S_FREE) begin
        free_head.idx   <= cur.idx;
        free_head.valid <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_q <= cmd;
          key_q <= key[KEY_W-1:0];
          val_q <= value[VAL_W-1:0];
          bkt   <= BKT_FAST ? key_ext[BKT_W-1:0] : '0;
          cnt   <= CNT_W'(KEY_W - 1);
        end
      end
      S_HASH: begin
        bkt <= rem_next;
        cnt <= cnt - CNT_W'(1);
      end
      S_HEAD: begin
        res_found <= 1'b0;
        res_value <= '0;
        res_status <= (cmd_q == CMD_PUT) ? STAT_FULL : STAT_MISS;
      end
      S_PUT: res_status <= STAT_OK;
      S_FIRST: begin
        cur        <= bkt_rd;
        prev       <= '0;
        res_status <= STAT_MISS;
      end
      S_WALK: begin
        if (hit) begin
          res_status <= STAT_OK;
          res_found  <= 1'b1;
          res_value  <= val_rd;
        end else begin
          prev <= cur;
          cur  <= link_rd;
        end
      end
      S_RESULT: begin
        if (out_load) begin
          status    <= res_status;
          found     <= res_found;
          out_value <= res_value;
        end
      end
      default: ;
    endcase
  end

  assign value_out = VAL_PORT_W'(out_value);

endmodule

// ----- sv/chained_hash_table.sv -----
// Key/value table with separate chaining over a pool of cht_pkg::NODES nodes and
// cht_pkg::BUCKETS buckets. Each transaction is a put, get or remove and yields exactly
// one result: a put prepends a node to its bucket (newest key shadows older ones) or
// reports status 2 when the pool is empty; get and remove return the first match in the
// chain, and a miss returns status 1 with found and value_out zero. The block takes one
// transaction at a time; in_ready is high only while idle, and a finished result waits
// in the output register while the next transaction is taken. Each transaction reads its
// bucket head; a put that finds a free node then writes it, and get and remove walk the
// chain, reading one node per cycle from the node memories. A remove that hits also
// returns the node to the free pool. A result that is not taken holds the block in its
// result state until the output register frees up. With a bucket count that is not a
// power of two the bucket index is first reduced one key bit per cycle. No clearing pass
// is needed after reset: bucket heads and node links carry valid bits.
module chained_hash_table (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [cht_pkg::CMD_W-1:0]      cmd,
  input  logic [cht_pkg::KEY_PORT_W-1:0] key,
  input  logic [cht_pkg::VAL_PORT_W-1:0] value,
  input  logic                         in_valid,
  output logic                         in_ready,
  output logic [cht_pkg::STATUS_W-1:0]   status,
  output logic                         found,
  output logic [cht_pkg::VAL_PORT_W-1:0] value_out,
  output logic                         out_valid,
  input  logic                         out_ready
);
  import cht_pkg::*;

  mem_req_t         req;
  ptr_t             bkt_rd;
  ptr_t             link_rd;
  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] val_rd;

  cht_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .key       (key),
    .value     (value),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .status    (status),
    .found     (found),
    .value_out (value_out),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .req       (req),
    .bkt_rd    (bkt_rd),
    .key_rd    (key_rd),
    .val_rd    (val_rd),
    .link_rd   (link_rd)
  );

  cht_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .bkt_rd  (bkt_rd),
    .key_rd  (key_rd),
    .val_rd  (val_rd),
    .link_rd (link_rd)
  );

endmodule

// ----- sv/cht_checker.sv -----
`include "chained_hash_table_assert.svh"

module cht_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [cht_pkg::STATUS_W-1:0]   status,
  input logic                         found,
  input logic [cht_pkg::VAL_PORT_W-1:0] value_out,
  input logic                         out_valid,
  input logic                         out_ready
);
  import cht_pkg::*;

  // A result that is not taken stays on the port.
  `CHT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(found) && $stable(value_out), "result changed while stalled")

  // The block works on one transaction at a time.
  `CHT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after an accepted transaction")

  `CHT_ASSERT_SAME(a_found_ok, out_valid && found, status == STAT_OK, "found set without status ok")

  `CHT_ASSERT_SAME(a_miss_zero, out_valid && status != STAT_OK, !found && value_out == '0, "failed transaction returns data")

endmodule

bind chained_hash_table cht_checker u_cht_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .status    (status),
  .found     (found),
  .value_out (value_out),
  .out_valid (out_valid),
  .out_ready (out_ready)
);
